>>> rtl/hlf_pkg.sv
// Shared types, constants and the fit step table of the histogram edge line fit.
`timescale 1ns / 1ps
package hlf_pkg;

	localparam int NUM_BINS = 512;

	localparam int IDX_W   = 10;
	localparam int CNT_W   = 24;
	localparam int EDGE_W  = 32;
	localparam int STAT_W  = 2;
	localparam int AXIS_W  = 16;
	localparam int BW_W    = 16;

	localparam int N_W     = 11;
	localparam int SX_W    = 19;
	localparam int SXX_W   = 27;
	localparam int SY_W    = 34;
	localparam int SXY_W   = 43;

	localparam int MA_W    = 27;
	localparam int MB_W    = 24;
	localparam int P_W     = MA_W + MB_W;
	localparam int CHUNK_W = MB_W;
	localparam int ACC_W   = 64;

	localparam int FRAC_W    = 12;
	localparam int TIME_SH   = 8 + FRAC_W;
	localparam int NUM_MAG_W = 62;
	localparam int M_W       = 55;
	localparam int DVD_W     = NUM_MAG_W + FRAC_W;
	localparam int DIV_CNT_W = $clog2(DVD_W);
	localparam int QC_W      = 46;

	localparam int STEP_W  = 4;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	localparam logic [STEP_W-1:0] STEP_D_DONE   = 4'd1;
	localparam logic [STEP_W-1:0] STEP_M_DONE   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_NUM_DONE = 4'd9;
	localparam logic [STEP_W-1:0] STEP_SCALE    = 4'd10;
	localparam logic [STEP_W-1:0] STEP_LAST     = 4'd11;

	typedef struct packed {
		logic [IDX_W-1:0] bin_index;
		logic [CNT_W-1:0] bin_count;
		logic             last_bin;
	} bin_in_t;

	typedef struct packed {
		logic signed [EDGE_W-1:0] edge_time_q8;
		logic [STAT_W-1:0]        fit_status;
	} fit_out_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_FLAT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_FIRST = 2'd0,
		REG_LAST  = 2'd1,
		REG_AXIS  = 2'd2,
		REG_WIDTH = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		A_IDX, A_N, A_SX, A_SXX, A_BW
	} a_sel_t;

	typedef enum logic [3:0] {
		B_CNT, B_IDX, B_N, B_SX, B_SXY_LO, B_SXY_HI, B_SY_LO, B_SY_HI, B_Q_LO, B_Q_HI
	} b_sel_t;

	typedef enum logic [1:0] {
		ACC_ADD, ACC_SUB, ACC_SGN
	} acc_mode_t;

	typedef struct packed {
		a_sel_t    a_sel;
		b_sel_t    b_sel;
		logic      hi;    // product weighs 2^CHUNK_W
		logic      clr;   // start a new sum
		acc_mode_t mode;
	} fit_op_t;

	// d = n*Sxx - Sx*Sx, m = n*Sxy - Sx*Sy, num = Sx*Sxy - Sxx*Sy, then x * width
	function automatic fit_op_t fit_op(input logic [STEP_W-1:0] step);
		fit_op_t op;
		op = '{A_SXX, B_N, 1'b0, 1'b1, ACC_ADD};
		case (step)
			4'd0:    op = '{A_SXX, B_N,      1'b0, 1'b1, ACC_ADD};
			4'd1:    op = '{A_SX,  B_SX,     1'b0, 1'b0, ACC_SUB};
			4'd2:    op = '{A_N,   B_SXY_LO, 1'b0, 1'b1, ACC_ADD};
			4'd3:    op = '{A_N,   B_SXY_HI, 1'b1, 1'b0, ACC_ADD};
			4'd4:    op = '{A_SX,  B_SY_LO,  1'b0, 1'b0, ACC_SUB};
			4'd5:    op = '{A_SX,  B_SY_HI,  1'b1, 1'b0, ACC_SUB};
			4'd6:    op = '{A_SX,  B_SXY_LO, 1'b0, 1'b1, ACC_ADD};
			4'd7:    op = '{A_SX,  B_SXY_HI, 1'b1, 1'b0, ACC_ADD};
			4'd8:    op = '{A_SXX, B_SY_LO,  1'b0, 1'b0, ACC_SUB};
			4'd9:    op = '{A_SXX, B_SY_HI,  1'b1, 1'b0, ACC_SUB};
			4'd10:   op = '{A_BW,  B_Q_LO,   1'b0, 1'b0, ACC_SGN};
			4'd11:   op = '{A_BW,  B_Q_HI,   1'b1, 1'b0, ACC_SGN};
			default: op = '{A_SXX, B_N,      1'b0, 1'b1, ACC_ADD};
		endcase
		return op;
	endfunction

endpackage

>>> rtl/histogram_edge_line_fit.sv
// Histogram edge finder: windowed least-squares line fit and zero-crossing time.
`timescale 1ns / 1ps
//
//  channel   dir  handshake               beat
//  bin       in   bin_valid / bin_ready   bin_data : bin_index, bin_count, last_bin
//  fit       out  fit_valid / fit_ready   fit_data : edge_time_q8, fit_status
//  cfg       in   APB (psel/penable)      fit_first_bin, fit_last_bin, axis_low_time,
//                                         bin_width_q8 at 0x0, 0x4, 0x8, 0xC
//
//  Sequence: a bin outside the window is taken without a sum update; a bin inside
//  it makes two passes through the shared 27x24 multiplier, then the sum update. A
//  last bin adds the fit: 12 multiply/accumulate passes (multiply, accumulate,
//  check), a restoring divider over the 74-bit dividend and the check, quotient
//  fix and done control states; a too-few, non-positive-d or zero-slope exit ends early.
//  Reset: sums, count and sequencer clear, the configuration takes its defaults at once; no clearing pass.
//  Stalls: the result sits in an output register, so bins keep flowing while it
//  waits; only a second fit result waits in the done state for the register to free.
module histogram_edge_line_fit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      bin_valid,
	output logic                      bin_ready,
	input  hlf_pkg::bin_in_t          bin_data,
	output logic                      fit_valid,
	input  logic                      fit_ready,
	output hlf_pkg::fit_out_t         fit_data,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [hlf_pkg::APB_AW-1:0] paddr,
	input  logic [hlf_pkg::APB_DW-1:0] pwdata,
	output logic [hlf_pkg::APB_DW-1:0] prdata,
	output logic                      pready
);
	import hlf_pkg::*;

	// one-hot sequencer
	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_B_XY  = 11'b000_0000_0010,
		S_B_XX  = 11'b000_0000_0100,
		S_B_ADD = 11'b000_0000_1000,
		S_F_CHK = 11'b000_0001_0000,
		S_F_MUL = 11'b000_0010_0000,
		S_F_ACC = 11'b000_0100_0000,
		S_F_EVL = 11'b000_1000_0000,
		S_DIV   = 11'b001_0000_0000,
		S_QFIX  = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// configuration
	logic [IDX_W-1:0]         first_q, last_q;
	logic signed [AXIS_W-1:0] axis_q;
	logic [BW_W-1:0]          bw_q;

	// running sums
	logic [N_W-1:0]   n_q;
	logic [SX_W-1:0]  sx_q;
	logic [SXX_W-1:0] sxx_q;
	logic [SY_W-1:0]  sy_q;
	logic [SXY_W-1:0] sxy_q;

	// datapath
	bin_in_t                 bin_q;
	logic [P_W-1:0]          p_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [M_W-1:0]          m_q;
	logic                    neg_q;
	logic [DVD_W-1:0]        dvd_q;
	logic [M_W-1:0]          rem_q;
	logic [EDGE_W-1:0]       res_edge_q;
	status_t                 res_status_q;
	logic                    fit_valid_q;
	fit_out_t                fit_data_q;

	// --- APB ---
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_FIRST: prdata = APB_DW'(first_q);
			REG_LAST:  prdata = APB_DW'(last_q);
			REG_AXIS:  prdata = {{(APB_DW-AXIS_W){axis_q[AXIS_W-1]}}, axis_q};
			REG_WIDTH: prdata = APB_DW'(bw_q);
			default:   prdata = '0;
		endcase
	end

	// --- input acceptance and window test ---
	logic bin_acc, bin_hit;
	assign bin_ready = (state_q == S_IDLE);
	assign bin_acc   = bin_valid && bin_ready;
	assign bin_hit   = (bin_data.bin_index != '0) &&
		(32'(bin_data.bin_index) <= 32'(NUM_BINS)) &&
		(bin_data.bin_index >= first_q) && (bin_data.bin_index <= last_q);

	// --- shared multiplier operand select ---
	fit_op_t op;
	a_sel_t  a_sel;
	b_sel_t  b_sel;
	logic [MA_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	logic [P_W-1:0]  prod;
	logic [QC_W-1:0] qc;

	// quotient magnitude clamped; beyond it the result saturates anyway
	assign qc = (|dvd_q[DVD_W-1:QC_W]) ? '1 : dvd_q[QC_W-1:0];
	assign op = fit_op(step_q);

	always_comb begin
		a_sel = op.a_sel;
		b_sel = op.b_sel;
		case (state_q)
			S_B_XY:  begin a_sel = A_IDX; b_sel = B_CNT; end
			S_B_XX:  begin a_sel = A_IDX; b_sel = B_IDX; end
			default: ;
		endcase
	end

	always_comb begin
		case (a_sel)
			A_IDX:   mul_a = MA_W'(bin_q.bin_index);
			A_N:     mul_a = MA_W'(n_q);
			A_SX:    mul_a = MA_W'(sx_q);
			A_SXX:   mul_a = MA_W'(sxx_q);
			A_BW:    mul_a = MA_W'(bw_q);
			default: mul_a = '0;
		endcase
		case (b_sel)
			B_CNT:    mul_b = bin_q.bin_count;
			B_IDX:    mul_b = MB_W'(bin_q.bin_index);
			B_N:      mul_b = MB_W'(n_q);
			B_SX:     mul_b = MB_W'(sx_q);
			B_SXY_LO: mul_b = sxy_q[CHUNK_W-1:0];
			B_SXY_HI: mul_b = MB_W'(sxy_q[SXY_W-1:CHUNK_W]);
			B_SY_LO:  mul_b = sy_q[CHUNK_W-1:0];
			B_SY_HI:  mul_b = MB_W'(sy_q[SY_W-1:CHUNK_W]);
			B_Q_LO:   mul_b = qc[CHUNK_W-1:0];
			B_Q_HI:   mul_b = MB_W'(qc[QC_W-1:CHUNK_W]);
			default:  mul_b = '0;
		endcase
	end

	assign prod = P_W'(mul_a) * P_W'(mul_b);

	// --- accumulator: registered product, shifted, added or subtracted ---
	logic [ACC_W-1:0] acc_term, acc_base, acc_nxt, acc_abs, acc_init;
	logic             acc_sub;

	assign acc_term = op.hi ? {p_q[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} : ACC_W'(p_q);
	assign acc_base = op.clr ? '0 : acc_q;
	assign acc_sub  = (op.mode == ACC_SUB) || ((op.mode == ACC_SGN) && neg_q);
	assign acc_nxt  = acc_sub ? (acc_base - acc_term) : (acc_base + acc_term);
	assign acc_abs  = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;

	// time = axis*2^20 + 2048 (round half up) - 2048*width, then + |x|*width signed
	assign acc_init = {{(ACC_W-AXIS_W-TIME_SH){axis_q[AXIS_W-1]}}, axis_q, {TIME_SH{1'b0}}}
		+ ACC_W'(1 << (FRAC_W - 1))
		- (ACC_W'(bw_q) << (FRAC_W - 1));

	// --- restoring divider step, one quotient bit per cycle ---
	logic [M_W:0]   div_sh;
	logic [M_W+1:0] div_diff;
	logic           div_take;

	assign div_sh   = {rem_q, dvd_q[DVD_W-1]};
	assign div_diff = {1'b0, div_sh} - {2'b00, m_q};
	assign div_take = !div_diff[M_W+1];

	// --- final saturation to 32 bits after the Q20 to Q8 shift ---
	logic [ACC_W-EDGE_W-FRAC_W:0] acc_top;
	logic [EDGE_W-1:0]            edge_sat;

	assign acc_top  = acc_q[ACC_W-1:EDGE_W+FRAC_W-1];
	assign edge_sat = ((&acc_top) || !(|acc_top)) ? acc_q[EDGE_W+FRAC_W-1:FRAC_W] :
		(acc_q[ACC_W-1] ? {1'b1, {(EDGE_W-1){1'b0}}} : {1'b0, {(EDGE_W-1){1'b1}}});

	// --- output register ---
	logic out_free;
	assign out_free  = !fit_valid_q || fit_ready;
	assign fit_valid = fit_valid_q;
	assign fit_data  = fit_data_q;

	// --- control, sums and configuration ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			div_cnt_q   <= '0;
			fit_valid_q <= 1'b0;
			first_q     <= IDX_W'(1);
			last_q      <= IDX_W'(NUM_BINS);
			axis_q      <= '0;
			bw_q        <= BW_W'(256);
			n_q         <= '0;
			sx_q        <= '0;
			sxx_q       <= '0;
			sy_q        <= '0;
			sxy_q       <= '0;
		end else begin
			if (cfg_wr) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_FIRST: first_q <= pwdata[IDX_W-1:0];
					REG_LAST:  last_q  <= pwdata[IDX_W-1:0];
					REG_AXIS:  axis_q  <= pwdata[AXIS_W-1:0];
					REG_WIDTH: bw_q    <= pwdata[BW_W-1:0];
					default:   ;
				endcase
			end

			// a new result loading in the same cycle keeps valid up
			if (fit_valid_q && fit_ready && !(state_q == S_DONE && out_free)) begin
				fit_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (bin_acc) begin
						if (bin_hit) begin
							state_q <= S_B_XY;
						end else if (bin_data.last_bin) begin
							state_q <= S_F_CHK;
						end
					end
				end
				S_B_XY: state_q <= S_B_XX;
				S_B_XX: begin
					sxy_q   <= sxy_q + p_q[SXY_W-1:0];
					state_q <= S_B_ADD;
				end
				S_B_ADD: begin
					sxx_q   <= sxx_q + p_q[SXX_W-1:0];
					sx_q    <= sx_q + SX_W'(bin_q.bin_index);
					sy_q    <= sy_q + SY_W'(bin_q.bin_count);
					n_q     <= n_q + 1'b1;
					state_q <= bin_q.last_bin ? S_F_CHK : S_IDLE;
				end
				S_F_CHK: begin
					step_q  <= '0;
					state_q <= (n_q < N_W'(2)) ? S_DONE : S_F_MUL;
				end
				S_F_MUL: state_q <= S_F_ACC;
				S_F_ACC: state_q <= S_F_EVL;
				S_F_EVL: begin
					case (step_q)
						STEP_D_DONE: begin
							step_q  <= step_q + 1'b1;
							state_q <= (acc_q[ACC_W-1] || (acc_q == '0)) ? S_DONE : S_F_MUL;
						end
						STEP_M_DONE: begin
							step_q  <= step_q + 1'b1;
							state_q <= (acc_q == '0) ? S_DONE : S_F_MUL;
						end
						STEP_NUM_DONE: begin
							div_cnt_q <= '0;
							state_q   <= S_DIV;
						end
						STEP_LAST: state_q <= S_DONE;
						default: begin
							step_q  <= step_q + 1'b1;
							state_q <= S_F_MUL;
						end
					endcase
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
						state_q <= S_QFIX;
					end
				end
				S_QFIX: begin
					step_q  <= STEP_SCALE;
					state_q <= S_F_MUL;
				end
				S_DONE: begin
					if (out_free) begin
						fit_valid_q <= 1'b1;
						n_q         <= '0;
						sx_q        <= '0;
						sxx_q       <= '0;
						sy_q        <= '0;
						sxy_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// --- datapath registers ---
	always_ff @(posedge clk) begin
		if (bin_acc) begin
			bin_q <= bin_data;
		end
		if (state_q == S_DONE && out_free) begin
			fit_data_q.edge_time_q8 <= res_edge_q;
			fit_data_q.fit_status   <= res_status_q;
		end

		case (state_q)
			S_B_XY, S_B_XX, S_F_MUL: p_q <= prod;
			S_F_CHK: begin
				res_edge_q   <= '0;
				res_status_q <= ST_FEW;
			end
			S_F_ACC: acc_q <= acc_nxt;
			S_F_EVL: begin
				case (step_q)
					STEP_M_DONE: begin
						res_status_q <= ST_FLAT;
						m_q          <= acc_abs[M_W-1:0];
						neg_q        <= acc_q[ACC_W-1];
					end
					STEP_NUM_DONE: begin
						neg_q <= neg_q ^ acc_q[ACC_W-1];
						dvd_q <= {acc_abs[NUM_MAG_W-1:0], {FRAC_W{1'b0}}};
						rem_q <= '0;
					end
					STEP_LAST: begin
						res_edge_q   <= edge_sat;
						res_status_q <= ST_OK;
					end
					default: ;
				endcase
			end
			S_DIV: begin
				rem_q <= div_take ? div_diff[M_W-1:0] : div_sh[M_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], div_take};
			end
			S_QFIX: begin
				// floor for a negative quotient with a remainder left
				dvd_q <= dvd_q + DVD_W'(neg_q && (rem_q != '0));
				acc_q <= acc_init;
			end
			default: ;
		endcase
	end

	// --- checks ---
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (m_q != '0))
		else $error("divide with zero divisor");

	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (n_q == '0 && sx_q == '0 && sxy_q == '0))
		else $error("sums not cleared after result");

	a_bad_fit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fit_valid_q && fit_data_q.fit_status != ST_OK) |-> (fit_data_q.edge_time_q8 == '0))
		else $error("failed fit carries a nonzero time");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_F_MUL) |-> (step_q <= STEP_LAST))
		else $error("fit step out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(fit_valid_q && !fit_ready) |=> fit_valid_q)
		else $error("pending result dropped");

endmodule
